/* src/sbda_pkg.sv */
// Shared types and constants for the signed binary to decimal ASCII converter.
`timescale 1ns / 1ps
`default_nettype none
package sbda_pkg;

	localparam int DIGIT_W = 4;

	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_MINUS = 8'd45;

	localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
	localparam logic [DIGIT_W-1:0] DABBLE_ADD   = 4'd3;

	typedef struct packed {
		logic clear;
		logic dabble;
		logic shift;
	} sbda_cmd_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CONV = 5'b00010,
		ST_SKIP = 5'b00100,
		ST_SIGN = 5'b01000,
		ST_EMIT = 5'b10000
	} sbda_state_t;

endpackage
`default_nettype wire

/* src/signed_binary_to_decimal_ascii.sv */
// Top level: signed integer to decimal ASCII text, one character per beat.
// After the accepting edge the magnitude is shifted bit-serially through the
// shift-add-3 digit chain, then leading zero digits are shifted out (at least
// one digit is kept), a minus sign is emitted if negative, then the digits,
// most significant first. A new value is accepted only when idle, after the last character.
// Reset clears the controller to idle; the receiver cannot stall the output.
`timescale 1ns / 1ps
`default_nettype none
module signed_binary_to_decimal_ascii
	import sbda_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic [VALUE_WIDTH-1:0] value,
	output logic                        text_valid,
	output logic [7:0]                  text_char,
	output logic                        last_char
);

	localparam int NDIG  = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
	localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
	localparam int REM_W = $clog2(NDIG + 1);

	sbda_state_t            state_q, state_d;
	logic [VALUE_WIDTH-1:0] mag_q;
	logic                   neg_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [REM_W-1:0]       rem_q;
	logic                   accept;
	logic                   rem_one;
	sbda_cmd_t              cmd;

	logic [DIGIT_W-1:0] dig  [NDIG];
	logic               cout [NDIG];
	logic [DIGIT_W-1:0] top;

	assign accept  = start && (state_q == ST_IDLE);
	assign rem_one = (rem_q == REM_W'(1));
	assign top     = dig[NDIG-1];

	genvar gi;
	generate
		for (gi = 0; gi < NDIG; gi++) begin : g_cell
			if (gi == 0) begin : g_first
				sbda_cell u_cell (
					.clk      (clk),
					.cmd      (cmd),
					.bit_in   (mag_q[VALUE_WIDTH-1]),
					.digit_in ('0),
					.bit_out  (cout[gi]),
					.digit    (dig[gi])
				);
			end else begin : g_rest
				sbda_cell u_cell (
					.clk      (clk),
					.cmd      (cmd),
					.bit_in   (cout[gi-1]),
					.digit_in (dig[gi-1]),
					.bit_out  (cout[gi]),
					.digit    (dig[gi])
				);
			end
		end
	endgenerate

	always_comb begin
		state_d    = state_q;
		cmd.clear  = 1'b0;
		cmd.dabble = 1'b0;
		cmd.shift  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.clear = 1'b1;
					state_d   = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.dabble = 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				if ((top == '0) && !rem_one) begin
					cmd.shift = 1'b1;
				end else begin
					state_d = neg_q ? ST_SIGN : ST_EMIT;
				end
			end
			ST_SIGN: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.shift = 1'b1;
				if (rem_one) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q <= value[VALUE_WIDTH-1];
			mag_q <= value[VALUE_WIDTH-1] ? (~value + VALUE_WIDTH'(1)) : value;
			cnt_q <= CNT_W'(VALUE_WIDTH);
			rem_q <= REM_W'(NDIG);
		end else begin
			if (cmd.dabble) begin
				mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (cmd.shift) begin
				rem_q <= rem_q - REM_W'(1);
			end
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign text_valid = (state_q == ST_SIGN) || (state_q == ST_EMIT);
	assign text_char  = (state_q == ST_EMIT) ? (CHAR_ZERO + {4'b0000, top}) : CHAR_MINUS;
	assign last_char  = (state_q == ST_EMIT) && rem_one;

	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid |-> busy)
		else $error("text beat outside a conversion");

	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		last_char |-> text_valid)
		else $error("last flag without a text beat");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(text_valid && last_char) |=> !busy)
		else $error("still busy after the last character");

	a_start_conv: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !text_valid))
		else $error("accepted item did not enter conversion");

endmodule
`default_nettype wire

/* src/sbda_cell.sv */
// One decimal digit cell of the shift-add-3 chain.
`timescale 1ns / 1ps
`default_nettype none
module sbda_cell
	import sbda_pkg::*;
(
	input  wire logic               clk,
	input  wire sbda_cmd_t          cmd,
	input  wire logic               bit_in,
	input  wire logic [DIGIT_W-1:0] digit_in,
	output logic                    bit_out,
	output logic [DIGIT_W-1:0]      digit
);

	logic [DIGIT_W-1:0] digit_q;
	logic [DIGIT_W-1:0] adj;

	assign adj     = (digit_q >= DABBLE_LIMIT) ? (digit_q + DABBLE_ADD) : digit_q;
	assign bit_out = adj[DIGIT_W-1];
	assign digit   = digit_q;

	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			digit_q <= '0;
		end else if (cmd.dabble) begin
			digit_q <= {adj[DIGIT_W-2:0], bit_in};
		end else if (cmd.shift) begin
			digit_q <= digit_in;
		end
	end

endmodule
`default_nettype wire

/* tb/signed_binary_to_decimal_ascii_tb.sv */
// Self-checking testbench for the signed binary to decimal ASCII converter.
`timescale 1ns / 1ps
module signed_binary_to_decimal_ascii_tb;
	import sbda_pkg::*;

	localparam int VALUE_WIDTH  = 32;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 60;

	typedef struct packed {
		logic [7:0] glyph;
		logic       last;
	} text_beat_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic [VALUE_WIDTH-1:0] value = '0;
	logic                   busy;
	logic                   text_valid;
	logic [7:0]             text_char;
	logic                   last_char;

	text_beat_t expected_text[$];
	int         mismatches = 0;
	int         numbers_sent = 0;
	int         chars_checked = 0;
	int         cycles = 0;

	signed_binary_to_decimal_ascii #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.value(value),
		.text_valid(text_valid),
		.text_char(text_char),
		.last_char(last_char)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void predict_decimal_text(input logic [VALUE_WIDTH-1:0] num);
		logic [VALUE_WIDTH:0] mag;
		logic [3:0]           digits[$];
		text_beat_t           beat;
		if (num[VALUE_WIDTH-1]) begin
			mag = (~{1'b1, num}) + 1'b1;
		end else begin
			mag = {1'b0, num};
		end
		do begin
			digits.push_front(4'(mag % 10));
			mag = mag / 10;
		end while (mag != 0);
		if (num[VALUE_WIDTH-1]) begin
			beat.glyph = CHAR_MINUS;
			beat.last  = 1'b0;
			expected_text.push_back(beat);
		end
		foreach (digits[i]) begin
			beat.glyph = CHAR_ZERO + 8'(digits[i]);
			beat.last  = (i == digits.size() - 1);
			expected_text.push_back(beat);
		end
	endfunction

	function automatic logic [VALUE_WIDTH-1:0] pick_value();
		logic [VALUE_WIDTH-1:0] raw;
		int                     shift;
		raw   = $urandom;
		shift = $urandom_range(0, VALUE_WIDTH - 1);
		case ($urandom_range(0, 3))
			0: begin
				return raw;
			end
			1: begin
				return $signed(raw) >>> shift;
			end
			2: begin
				return raw >> shift;
			end
			default: begin
				if ($urandom_range(0, 1))
					return 32'(0) - 32'($urandom_range(0, 20));
				return 32'($urandom_range(0, 20));
			end
		endcase
	endfunction

	task automatic send_value(input logic [VALUE_WIDTH-1:0] num, input int idle_pct);
		logic offered;
		offered = 1'b0;
		do begin
			offered = ($urandom_range(0, 99) >= idle_pct);
			start <= offered;
			value <= offered ? num : VALUE_WIDTH'($urandom);
			@(posedge clk);
		end while (!(offered && !busy));
		predict_decimal_text(num);
		numbers_sent++;
	endtask

	task automatic test_extremes();
		logic [VALUE_WIDTH-1:0] picks[] = '{
			32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99,
			-32'sd99, 32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
			32'd999999999, 32'd1000000000, -32'sd1000000000, 32'd2000000000,
			32'h5555_5555, 32'hAAAA_AAAA, -32'sd2
		};
		foreach (picks[i]) begin
			send_value(picks[i], 9);
		end
	endtask

	task automatic test_random_values(input int idle_pct, input int count);
		repeat (count) begin
			send_value(pick_value(), idle_pct);
		end
	endtask

	always @(posedge clk) begin : check_text
		text_beat_t want;
		if (arst_n && text_valid) begin
			if (expected_text.size() == 0) begin
				$display("%0t: unexpected beat: expected none, actual char %0d last %b",
					$time, text_char, last_char);
				mismatches++;
			end else begin
				want = expected_text.pop_front();
				if (text_char !== want.glyph) begin
					$display("%0t: text_char mismatch: expected %0d, actual %0d",
						$time, want.glyph, text_char);
					mismatches++;
				end
				if (last_char !== want.last) begin
					$display("%0t: last_char mismatch: expected %b, actual %b",
						$time, want.last, last_char);
					mismatches++;
				end
				chars_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycles);
			$display("signed_binary_to_decimal_ascii regression: fail");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_random_values(9, 70);
		test_random_values(47, 65);
		test_random_values(0, 65);
		start <= 1'b0;
		while (expected_text.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Converted %0d numbers into %0d checked characters: extremes, then random",
			numbers_sent, chars_checked);
		$display("values under light, heavy and no sender gaps; %0d mismatches.", mismatches);
		if (mismatches == 0) begin
			$display("signed_binary_to_decimal_ascii regression: pass");
		end else begin
			$display("signed_binary_to_decimal_ascii regression: fail");
		end
		$finish;
	end

endmodule

/* filelist.f */
src/sbda_pkg.sv
src/sbda_cell.sv
src/signed_binary_to_decimal_ascii.sv
tb/signed_binary_to_decimal_ascii_tb.sv
